[sv/isc_pkg.sv]
// ============================================================================
// isc_pkg - shared types and constants for the IMU poll stuck checker
// Status codes, register indexes, lane counts and the merge verdict struct.
// ============================================================================
`default_nettype none

package isc_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned NUM_LANES = 2 * NUM_AXES;   // accel x/y/z, gyro x/y/z
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned SMALL_W   = 8;

    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
    localparam logic [SMALL_W-1:0] REPEAT_MAX   = '1;
    localparam logic [SMALL_W-1:0] DIV_RESET    = 8'd10;
    localparam logic [SMALL_W-1:0] LIMIT_RESET  = 8'd5;

    typedef logic [DATA_W-1:0]  t_word;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [SMALL_W-1:0] t_small;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_OFS_X  = 3'd0,
        CFG_GYRO_OFS_Y  = 3'd1,
        CFG_GYRO_OFS_Z  = 3'd2,
        CFG_MAG_DIVIDER = 3'd3,
        CFG_REPEAT_LIM  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_MAG_TAKEN  = 3'd1,
        ST_MAG_FAILED = 3'd2,
        ST_READ_FAIL  = 3'd3,
        ST_STUCK      = 3'd4
    } t_status;

    // Decision of the merge stage for one poll
    typedef struct packed {
        logic    store;        // poll accepted: latch raw, publish
        logic    mag_take;     // mag sample due and good: load held mag
        t_small  repeat_count;
        t_small  mag_phase;
        t_status status;
        t_count  read_fails;
        t_count  mag_fails;
    } t_verdict;

endpackage

`default_nettype wire

[sv/isc_lane.sv]
// ============================================================================
// isc_lane - one accel/gyro axis lane
// Compares the raw reading with the last stored one and forms the published
// value (raw minus offset, 16-bit wrap; offset is zero for accel lanes).
// ============================================================================
`default_nettype none

module isc_lane (
    input  wire isc_pkg::t_word i_raw,
    input  wire isc_pkg::t_word i_last,
    input  wire isc_pkg::t_word i_offset,
    output logic                o_same,
    output isc_pkg::t_word      o_pub
);

    assign o_same = (i_raw == i_last);
    assign o_pub  = i_raw - i_offset;

endmodule

`default_nettype wire

[sv/isc_merge.sv]
// ============================================================================
// isc_merge - merge stage of the lanes
// Folds the lane compare bits into a repeat decision and works out status,
// repeat count, mag phase and the saturating failure counters.
// ============================================================================
`default_nettype none

module isc_merge (
    input  wire [isc_pkg::NUM_LANES-1:0] i_lane_same,
    input  wire                          i_read_ok,
    input  wire                          i_mag_ok,
    input  wire isc_pkg::t_small         i_repeat_count,
    input  wire isc_pkg::t_small         i_repeat_limit,
    input  wire isc_pkg::t_small         i_mag_phase,
    input  wire isc_pkg::t_small         i_mag_divider,
    input  wire isc_pkg::t_count         i_read_fails,
    input  wire isc_pkg::t_count         i_mag_fails,
    output isc_pkg::t_verdict            o_verdict
);

    logic                       all_same;
    isc_pkg::t_small            rep_next;
    logic [isc_pkg::SMALL_W:0]  phase_sum;
    logic                       mag_due;
    isc_pkg::t_count            read_fails_inc;
    isc_pkg::t_count            mag_fails_inc;

    assign all_same       = &i_lane_same;
    assign phase_sum      = {1'b0, i_mag_phase} + {{isc_pkg::SMALL_W{1'b0}}, 1'b1};
    assign mag_due        = (phase_sum >= {1'b0, i_mag_divider});
    assign read_fails_inc = (i_read_fails == isc_pkg::CNT_MAX) ? i_read_fails
                                                               : i_read_fails + 1'b1;
    assign mag_fails_inc  = (i_mag_fails == isc_pkg::CNT_MAX) ? i_mag_fails
                                                              : i_mag_fails + 1'b1;

    always_comb begin
        if (all_same) begin
            rep_next = (i_repeat_count == isc_pkg::REPEAT_MAX) ? i_repeat_count
                                                               : i_repeat_count + 1'b1;
        end else begin
            rep_next = '0;
        end
    end

    always_comb begin
        o_verdict              = '0;
        o_verdict.repeat_count = i_repeat_count;
        o_verdict.mag_phase    = i_mag_phase;
        o_verdict.read_fails   = i_read_fails;
        o_verdict.mag_fails    = i_mag_fails;
        o_verdict.status       = isc_pkg::ST_ACCEPTED;
        priority if (!i_read_ok) begin
            o_verdict.read_fails = read_fails_inc;
            o_verdict.status     = isc_pkg::ST_READ_FAIL;
        end else if (rep_next >= i_repeat_limit) begin
            o_verdict.repeat_count = rep_next;
            o_verdict.read_fails   = read_fails_inc;
            o_verdict.status       = isc_pkg::ST_STUCK;
        end else begin
            o_verdict.repeat_count = rep_next;
            o_verdict.store        = 1'b1;
            if (mag_due) begin
                o_verdict.mag_phase = '0;
                if (i_mag_ok) begin
                    o_verdict.mag_take = 1'b1;
                    o_verdict.status   = isc_pkg::ST_MAG_TAKEN;
                end else begin
                    o_verdict.mag_fails = mag_fails_inc;
                    o_verdict.status    = isc_pkg::ST_MAG_FAILED;
                end
            end else begin
                o_verdict.mag_phase = phase_sum[isc_pkg::SMALL_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[sv/imu_sample_stuck_check.sv]
// ============================================================================
// imu_sample_stuck_check - IMU poll acceptance and stuck-sensor check
// Six axis lanes compare each poll with the last accepted raw poll and form
// the published accel/gyro values; a merge stage decides status, repeat
// count, mag sampling and failure counters.
// ============================================================================
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-------------------------------
//  poll    | in        | i_valid / o_stall      | accel, gyro, read_ok, mag, mag_ok
//  result  | out       | o_valid / i_stall      | published values, status, counts
//  config  | in        | i_cfg_valid / o_cfg_ready | register index + write data
//
//  One poll per cycle while o_stall is low: lanes and merge sit in front of
//  the state registers, and the result register loads the same next values,
//  so an unstalled beat goes straight from its poll into the result register.
//  The poll/state update loop runs through the state registers alone.
//  While a result beat is stalled, one more poll is taken into the state
//  registers; o_stall (registered, never looks at i_stall) then stays high
//  until that beat moves into the result register as the stalled one leaves.
//  Synchronous reset; o_stall stays high for the first cycle after reset.
//  Config is always ready and must only be written while the block is idle.
//
`default_nettype none

module imu_sample_stuck_check (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // poll channel
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [15:0]  i_accel_x,
    input  wire signed [15:0]  i_accel_y,
    input  wire signed [15:0]  i_accel_z,
    input  wire signed [15:0]  i_gyro_x,
    input  wire signed [15:0]  i_gyro_y,
    input  wire signed [15:0]  i_gyro_z,
    input  wire                i_read_ok,
    input  wire signed [15:0]  i_mag_x,
    input  wire signed [15:0]  i_mag_y,
    input  wire signed [15:0]  i_mag_z,
    input  wire                i_mag_ok,
    // result channel
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_out_accel_x,
    output logic signed [15:0] o_out_accel_y,
    output logic signed [15:0] o_out_accel_z,
    output logic signed [15:0] o_out_gyro_x,
    output logic signed [15:0] o_out_gyro_y,
    output logic signed [15:0] o_out_gyro_z,
    output logic signed [15:0] o_out_mag_x,
    output logic signed [15:0] o_out_mag_y,
    output logic signed [15:0] o_out_mag_z,
    output logic [2:0]         o_status,
    output logic [15:0]        o_read_failures,
    output logic [15:0]        o_mag_failures,
    // config channel
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [2:0]          i_cfg_index,
    input  wire [15:0]         i_cfg_data
);

    localparam int unsigned LANES = isc_pkg::NUM_LANES;
    localparam int unsigned AXES  = isc_pkg::NUM_AXES;

    // config registers
    isc_pkg::t_word   r_gyro_ofs [AXES];
    isc_pkg::t_small  r_mag_divider;
    isc_pkg::t_small  r_repeat_limit;

    // poll state
    isc_pkg::t_word   r_last_raw [LANES];
    isc_pkg::t_word   r_pub_ag   [LANES];
    isc_pkg::t_word   r_held_mag [AXES];
    isc_pkg::t_word   r_pub_mag  [AXES];
    isc_pkg::t_small  r_repeat_count;
    isc_pkg::t_small  r_mag_phase;
    isc_pkg::t_count  r_read_fails;
    isc_pkg::t_count  r_mag_fails;
    isc_pkg::t_status r_status;
    logic             r_run;

    // result register; r_pend marks a beat still parked in the state
    isc_pkg::t_word   r_res_ag   [LANES];
    isc_pkg::t_word   r_res_mag  [AXES];
    isc_pkg::t_status r_res_status;
    isc_pkg::t_count  r_res_read_fails;
    isc_pkg::t_count  r_res_mag_fails;
    logic             r_res_valid;
    logic             r_pend;

    isc_pkg::t_word    raw     [LANES];
    isc_pkg::t_word    mag_in  [AXES];
    isc_pkg::t_word    lane_ofs[LANES];
    isc_pkg::t_word    lane_pub[LANES];
    logic [LANES-1:0]  lane_same;
    isc_pkg::t_verdict verdict;
    isc_pkg::t_word    n_pub_ag [LANES];
    isc_pkg::t_word    n_pub_mag[AXES];
    logic              poll_acc;
    logic              res_taken;
    logic              res_free;

    assign raw[0] = i_accel_x;
    assign raw[1] = i_accel_y;
    assign raw[2] = i_accel_z;
    assign raw[3] = i_gyro_x;
    assign raw[4] = i_gyro_y;
    assign raw[5] = i_gyro_z;

    assign mag_in[0] = i_mag_x;
    assign mag_in[1] = i_mag_y;
    assign mag_in[2] = i_mag_z;

    // ---- handshake ----
    assign res_taken   = r_res_valid && !i_stall;
    assign res_free    = !r_res_valid || res_taken;
    assign o_stall     = !r_run || r_pend;
    assign poll_acc    = i_valid && !o_stall;
    assign o_valid     = r_res_valid;
    assign o_cfg_ready = 1'b1;

    // ---- lanes: accel lanes publish raw, gyro lanes subtract the offset ----
    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            if (g < AXES) begin : g_acc
                assign lane_ofs[g] = '0;
            end else begin : g_gyr
                assign lane_ofs[g] = r_gyro_ofs[g - AXES];
            end
            isc_lane u_lane (
                .i_raw    (raw[g]),
                .i_last   (r_last_raw[g]),
                .i_offset (lane_ofs[g]),
                .o_same   (lane_same[g]),
                .o_pub    (lane_pub[g])
            );
        end
    endgenerate

    // ---- merge ----
    isc_merge u_merge (
        .i_lane_same    (lane_same),
        .i_read_ok      (i_read_ok),
        .i_mag_ok       (i_mag_ok),
        .i_repeat_count (r_repeat_count),
        .i_repeat_limit (r_repeat_limit),
        .i_mag_phase    (r_mag_phase),
        .i_mag_divider  (r_mag_divider),
        .i_read_fails   (r_read_fails),
        .i_mag_fails    (r_mag_fails),
        .o_verdict      (verdict)
    );

    // published values after this poll, for a direct load of the result
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_pub_ag[l] = verdict.store ? lane_pub[l] : r_pub_ag[l];
        end
        for (int a = 0; a < AXES; a++) begin
            n_pub_mag[a] = verdict.store ? r_held_mag[a] : r_pub_mag[a];
        end
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_repeat_count <= '0;
            r_mag_phase    <= isc_pkg::DIV_RESET;
            r_read_fails   <= '0;
            r_mag_fails    <= '0;
            r_status       <= isc_pkg::ST_ACCEPTED;
            r_mag_divider  <= isc_pkg::DIV_RESET;
            r_repeat_limit <= isc_pkg::LIMIT_RESET;
            for (int a = 0; a < AXES; a++) begin
                r_gyro_ofs[a] <= '0;
                r_held_mag[a] <= '0;
                r_pub_mag[a]  <= '0;
            end
            for (int l = 0; l < LANES; l++) begin
                r_last_raw[l] <= '0;
                r_pub_ag[l]   <= '0;
            end
        end else begin
            r_run <= 1'b1;

            // config: unlisted indexes are ignored
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    isc_pkg::CFG_GYRO_OFS_X:  r_gyro_ofs[0]  <= i_cfg_data;
                    isc_pkg::CFG_GYRO_OFS_Y:  r_gyro_ofs[1]  <= i_cfg_data;
                    isc_pkg::CFG_GYRO_OFS_Z:  r_gyro_ofs[2]  <= i_cfg_data;
                    isc_pkg::CFG_MAG_DIVIDER: r_mag_divider  <= i_cfg_data[isc_pkg::SMALL_W-1:0];
                    isc_pkg::CFG_REPEAT_LIM:  r_repeat_limit <= i_cfg_data[isc_pkg::SMALL_W-1:0];
                    default: ;
                endcase
            end

            if (poll_acc) begin
                r_repeat_count <= verdict.repeat_count;
                r_mag_phase    <= verdict.mag_phase;
                r_read_fails   <= verdict.read_fails;
                r_mag_fails    <= verdict.mag_fails;
                r_status       <= verdict.status;
                if (verdict.store) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_last_raw[l] <= raw[l];
                        r_pub_ag[l]   <= lane_pub[l];
                    end
                    // published mag lags: it takes the held copy before update
                    for (int a = 0; a < AXES; a++) begin
                        r_pub_mag[a] <= r_held_mag[a];
                    end
                end
                if (verdict.mag_take) begin
                    for (int a = 0; a < AXES; a++) begin
                        r_held_mag[a] <= mag_in[a];
                    end
                end
            end
        end
    end

    // ---- result register: direct load, or from the state when parked ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid      <= 1'b0;
            r_pend           <= 1'b0;
            r_res_status     <= isc_pkg::ST_ACCEPTED;
            r_res_read_fails <= '0;
            r_res_mag_fails  <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_res_ag[l] <= '0;
            end
            for (int a = 0; a < AXES; a++) begin
                r_res_mag[a] <= '0;
            end
        end else if (r_pend) begin
            if (res_free) begin
                r_pend           <= 1'b0;
                r_res_valid      <= 1'b1;
                r_res_status     <= r_status;
                r_res_read_fails <= r_read_fails;
                r_res_mag_fails  <= r_mag_fails;
                for (int l = 0; l < LANES; l++) begin
                    r_res_ag[l] <= r_pub_ag[l];
                end
                for (int a = 0; a < AXES; a++) begin
                    r_res_mag[a] <= r_pub_mag[a];
                end
            end
        end else if (poll_acc) begin
            if (res_free) begin
                r_res_valid      <= 1'b1;
                r_res_status     <= verdict.status;
                r_res_read_fails <= verdict.read_fails;
                r_res_mag_fails  <= verdict.mag_fails;
                for (int l = 0; l < LANES; l++) begin
                    r_res_ag[l] <= n_pub_ag[l];
                end
                for (int a = 0; a < AXES; a++) begin
                    r_res_mag[a] <= n_pub_mag[a];
                end
            end else begin
                // result still stalled: this beat waits in the state registers
                r_pend <= 1'b1;
            end
        end else if (res_taken) begin
            r_res_valid <= 1'b0;
        end
    end

    // ---- result beat ----
    assign o_out_accel_x   = r_res_ag[0];
    assign o_out_accel_y   = r_res_ag[1];
    assign o_out_accel_z   = r_res_ag[2];
    assign o_out_gyro_x    = r_res_ag[3];
    assign o_out_gyro_y    = r_res_ag[4];
    assign o_out_gyro_z    = r_res_ag[5];
    assign o_out_mag_x     = r_res_mag[0];
    assign o_out_mag_y     = r_res_mag[1];
    assign o_out_mag_z     = r_res_mag[2];
    assign o_status        = r_res_status;
    assign o_read_failures = r_res_read_fails;
    assign o_mag_failures  = r_res_mag_fails;

endmodule

`default_nettype wire

[sv/isc_checker.sv]
// ============================================================================
// isc_checker - port-level checks for imu_sample_stuck_check
// Latency, back-pressure and counter behavior as seen on the ports.
// ============================================================================
`default_nettype none

module isc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        i_read_ok,
    input wire        o_valid,
    input wire        i_stall,
    input wire [2:0]  o_status,
    input wire [15:0] o_read_failures,
    input wire [15:0] o_mag_failures
);

    logic poll_acc;
    logic res_free;
    assign poll_acc = i_valid && !o_stall;
    assign res_free = !o_valid || !i_stall;

    // after every accepted poll a result beat is valid in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        poll_acc |=> o_valid)
        else $error("accepted poll gave no result beat");

    // a stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_status) && $stable(o_read_failures) &&
             $stable(o_mag_failures)))
        else $error("stalled result beat changed");

    // failed read with the result side free: status and saturating count
    a_read_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (poll_acc && res_free && !i_read_ok) |=>
            (o_status == isc_pkg::ST_READ_FAIL) &&
            ((o_read_failures == $past(o_read_failures) + 16'd1) ||
             (o_read_failures == isc_pkg::CNT_MAX)))
        else $error("read failure not counted");

    // mag failure count moves only on a mag failure
    a_mag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (poll_acc ##1 (o_status != isc_pkg::ST_MAG_FAILED)) |->
            (o_mag_failures == $past(o_mag_failures)))
        else $error("mag failure count moved without mag failure");

endmodule

bind imu_sample_stuck_check isc_checker u_isc_checker (.*);

`default_nettype wire

[tb/tb_imu_sample_stuck_check.sv]
// ============================================================================
// tb_imu_sample_stuck_check - self-checking bench for the IMU poll checker
// Drives sensor polls and register writes, predicts each published result
// from a cycle-free model of the acceptance rules and compares field by field.
// ============================================================================
`default_nettype none

module tb_imu_sample_stuck_check;

    import isc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned MAX_REPORTS = 10;

    // raw[0..2] accel x/y/z, raw[3..5] gyro x/y/z
    typedef logic [0:5][15:0] t_lanes;
    typedef logic [0:2][15:0] t_triple;

    typedef struct packed {
        t_lanes  raw;
        logic    read_ok;
        t_triple mag;
        logic    mag_ok;
    } t_poll;

    typedef struct packed {
        t_lanes  ag;
        t_triple mag;
        t_status status;
        t_count  read_fails;
        t_count  mag_fails;
    } t_pub;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [15:0] i_accel_x   = '0;
    logic [15:0] i_accel_y   = '0;
    logic [15:0] i_accel_z   = '0;
    logic [15:0] i_gyro_x    = '0;
    logic [15:0] i_gyro_y    = '0;
    logic [15:0] i_gyro_z    = '0;
    logic        i_read_ok   = 1'b0;
    logic [15:0] i_mag_x     = '0;
    logic [15:0] i_mag_y     = '0;
    logic [15:0] i_mag_z     = '0;
    logic        i_mag_ok    = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [15:0] o_out_accel_x, o_out_accel_y, o_out_accel_z;
    logic [15:0] o_out_gyro_x, o_out_gyro_y, o_out_gyro_z;
    logic [15:0] o_out_mag_x, o_out_mag_y, o_out_mag_z;
    logic [2:0]  o_status;
    logic [15:0] o_read_failures;
    logic [15:0] o_mag_failures;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    imu_sample_stuck_check DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_gyro_x        (i_gyro_x),
        .i_gyro_y        (i_gyro_y),
        .i_gyro_z        (i_gyro_z),
        .i_read_ok       (i_read_ok),
        .i_mag_x         (i_mag_x),
        .i_mag_y         (i_mag_y),
        .i_mag_z         (i_mag_z),
        .i_mag_ok        (i_mag_ok),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_accel_x   (o_out_accel_x),
        .o_out_accel_y   (o_out_accel_y),
        .o_out_accel_z   (o_out_accel_z),
        .o_out_gyro_x    (o_out_gyro_x),
        .o_out_gyro_y    (o_out_gyro_y),
        .o_out_gyro_z    (o_out_gyro_z),
        .o_out_mag_x     (o_out_mag_x),
        .o_out_mag_y     (o_out_mag_y),
        .o_out_mag_z     (o_out_mag_z),
        .o_status        (o_status),
        .o_read_failures (o_read_failures),
        .o_mag_failures  (o_mag_failures),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the checker: registers and state, at reset values
    // ------------------------------------------------------------------------
    t_triple gyro_ofs    = '0;
    t_small  mag_div     = DIV_RESET;
    t_small  dup_limit   = LIMIT_RESET;

    t_lanes  seen_raw    = '0;              // last accepted raw poll
    t_lanes  shown_ag    = '0;              // published accel / corrected gyro
    t_triple mag_hold    = '0;              // last good mag sample
    t_triple mag_shown   = '0;              // published mag, one accepted poll behind
    t_small  dup_run     = '0;              // consecutive identical polls
    t_small  mag_tick    = DIV_RESET;       // starts at the divider: first poll samples
    t_count  rd_fails    = '0;
    t_count  mg_fails    = '0;

    t_poll   poll_backlog[$];               // polls waiting for the driver
    t_pub    awaited_results[$];            // predicted beats, oldest first

    logic        idle_tx = 1'b0;            // sender inserts random gaps
    logic        idle_rx = 1'b0;            // receiver inserts random stalls
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned bad_count  = 0;
    int unsigned beats_seen = 0;
    int unsigned cycles     = 0;

    string field_name [12] = '{"out_accel_x", "out_accel_y", "out_accel_z",
                               "out_gyro_x", "out_gyro_y", "out_gyro_z",
                               "out_mag_x", "out_mag_y", "out_mag_z",
                               "status", "read_failures", "mag_failures"};

    function automatic t_count bump(input t_count c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic void load_setting(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_GYRO_OFS_X:  gyro_ofs[0] = data;
            CFG_GYRO_OFS_Y:  gyro_ofs[1] = data;
            CFG_GYRO_OFS_Z:  gyro_ofs[2] = data;
            CFG_MAG_DIVIDER: mag_div     = data[7:0];
            CFG_REPEAT_LIM:  dup_limit   = data[7:0];
            default: ;
        endcase
    endfunction

    // Applies one poll to the shadow state and returns the beat it publishes
    function automatic t_pub judge_poll(input t_poll p);
        t_pub     r;
        t_status  st;
        logic [8:0] nxt;
        if (!p.read_ok) begin
            // failed read leaves repeat count, raw copy and mag phase alone
            rd_fails = bump(rd_fails);
            st = ST_READ_FAIL;
        end else begin
            if (p.raw == seen_raw) begin
                if (dup_run != REPEAT_MAX)
                    dup_run = dup_run + 1'b1;
            end else begin
                dup_run = '0;
            end
            if (dup_run >= dup_limit) begin
                // stuck: count sticks until a different poll shows up
                rd_fails = bump(rd_fails);
                st = ST_STUCK;
            end else begin
                seen_raw = p.raw;
                for (int i = 0; i < 3; i++) begin
                    shown_ag[i]     = p.raw[i];
                    shown_ag[3 + i] = p.raw[3 + i] - gyro_ofs[i];
                end
                mag_shown = mag_hold;
                nxt = {1'b0, mag_tick} + 9'd1;
                // a divider lowered below the phase makes the next poll due
                if (nxt >= {1'b0, mag_div}) begin
                    mag_tick = '0;
                    if (p.mag_ok) begin
                        mag_hold = p.mag;
                        st = ST_MAG_TAKEN;
                    end else begin
                        mg_fails = bump(mg_fails);
                        st = ST_MAG_FAILED;
                    end
                end else begin
                    mag_tick = nxt[7:0];
                    st = ST_ACCEPTED;
                end
            end
        end
        r.ag         = shown_ag;
        r.mag        = mag_shown;
        r.status     = st;
        r.read_fails = rd_fails;
        r.mag_fails  = mg_fails;
        return r;
    endfunction

    function automatic void flag_mismatch(input string msg);
        bad_count++;
        if (bad_count <= MAX_REPORTS)
            $display("MISMATCH %s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // Poll driver: one beat at a time from the backlog; with idle_tx set, a random gap per beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_polls
        t_poll nxt_poll;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (!i_valid || !o_stall) begin
            // slot is free: last beat taken at this edge, or nothing offered
            if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (poll_backlog.size() != 0) begin
                nxt_poll = poll_backlog.pop_front();
                i_accel_x <= nxt_poll.raw[0];
                i_accel_y <= nxt_poll.raw[1];
                i_accel_z <= nxt_poll.raw[2];
                i_gyro_x  <= nxt_poll.raw[3];
                i_gyro_y  <= nxt_poll.raw[4];
                i_gyro_z  <= nxt_poll.raw[5];
                i_read_ok <= nxt_poll.read_ok;
                i_mag_x   <= nxt_poll.mag[0];
                i_mag_y   <= nxt_poll.mag[1];
                i_mag_z   <= nxt_poll.mag[2];
                i_mag_ok  <= nxt_poll.mag_ok;
                i_valid   <= 1'b1;
                send_gap = idle_tx ? $urandom_range(0, 7) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: random hold after every taken beat when idle_rx is set
    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall)
                stall_left = idle_rx ? $urandom_range(0, 7) : 0;
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: tracks register writes and accepted polls, checks result beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_poll       took;
        t_pub        want;
        logic [15:0] exp_v [12];
        logic [15:0] got_v [12];
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                load_setting(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                took.raw     = {i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y, i_gyro_z};
                took.read_ok = i_read_ok;
                took.mag     = {i_mag_x, i_mag_y, i_mag_z};
                took.mag_ok  = i_mag_ok;
                awaited_results.push_back(judge_poll(took));
            end
            if (o_valid && !i_stall) begin
                got_v = '{o_out_accel_x, o_out_accel_y, o_out_accel_z,
                          o_out_gyro_x, o_out_gyro_y, o_out_gyro_z,
                          o_out_mag_x, o_out_mag_y, o_out_mag_z,
                          16'(o_status), o_read_failures, o_mag_failures};
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d with no poll outstanding, status %0d",
                                            beats_seen, o_status));
                end else begin
                    want  = awaited_results.pop_front();
                    exp_v = '{want.ag[0], want.ag[1], want.ag[2],
                              want.ag[3], want.ag[4], want.ag[5],
                              want.mag[0], want.mag[1], want.mag[2],
                              16'(want.status), want.read_fails, want.mag_fails};
                    for (int f = 0; f < 12; f++) begin
                        if (exp_v[f] !== got_v[f])
                            flag_mismatch($sformatf("beat %0d %s: expected %h, got %h",
                                                    beats_seen, field_name[f],
                                                    exp_v[f], got_v[f]));
                    end
                end
                beats_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every predicted beat has been checked
    task automatic wait_drained();
        @(negedge i_clk);
        while (poll_backlog.size() != 0 || i_valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic t_poll rand_poll(input logic ok);
        t_poll p;
        for (int i = 0; i < 6; i++)
            p.raw[i] = 16'($urandom);
        for (int i = 0; i < 3; i++)
            p.mag[i] = 16'($urandom);
        p.read_ok = ok;
        p.mag_ok  = ($urandom_range(0, 3) != 0);
        return p;
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic choose_settings();
        t_small d;
        t_small l;
        case ($urandom_range(0, 5))
            0:       d = 8'd0;
            1:       d = 8'd1;
            2:       d = 8'd2;
            3:       d = 8'd255;
            default: d = 8'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 7))
            0:       l = 8'd0;
            1:       l = 8'd1;
            2:       l = 8'd255;
            default: l = 8'($urandom_range(2, 6));
        endcase
        write_reg(CFG_GYRO_OFS_X, pick_offset());
        write_reg(CFG_GYRO_OFS_Y, pick_offset());
        write_reg(CFG_GYRO_OFS_Z, pick_offset());
        write_reg(CFG_MAG_DIVIDER, {8'h00, d});
        write_reg(CFG_REPEAT_LIM, {8'h00, l});
    endtask

    // Mostly fresh or repeated polls with random content; some read failures
    // interleaved so that a failed read sits inside a run of repeats.
    task automatic queue_traffic(input int unsigned n);
        int unsigned cnt;
        int unsigned run;
        t_poll       p;
        t_poll       m;
        cnt = 0;
        while (cnt < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    poll_backlog.push_back(rand_poll(1'b0));
                    cnt++;
                end
                1: begin
                    p = rand_poll(1'b1);
                    p.raw = '0;
                    poll_backlog.push_back(p);
                    cnt++;
                end
                2, 3, 4: begin
                    p = rand_poll(1'b1);
                    run = $urandom_range(2, 8);
                    repeat (run) begin
                        if ($urandom_range(0, 4) == 0) begin
                            poll_backlog.push_back(rand_poll(1'b0));
                            cnt++;
                        end
                        // mag fields are not part of the repeat compare
                        m        = rand_poll(1'b1);
                        p.mag    = m.mag;
                        p.mag_ok = ($urandom_range(0, 3) != 0);
                        poll_backlog.push_back(p);
                        cnt++;
                    end
                end
                default: begin
                    poll_backlog.push_back(rand_poll(1'b1));
                    cnt++;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_test
        t_poll       p;
        t_poll       q;
        int unsigned k;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset settings (divider 10, limit 5, zero offsets)
        @(negedge i_clk);
        // all-zero poll equals the cleared raw copy: a repeat, still accepted,
        // and the first accepted poll takes the mag triple
        p = rand_poll(1'b1);
        p.raw    = '0;
        p.mag    = {16'h7FFF, 16'h8000, 16'hFFFF};
        p.mag_ok = 1'b1;
        poll_backlog.push_back(p);
        p.raw = {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
        p.mag = {16'h8000, 16'h7FFF, 16'h0000};
        poll_backlog.push_back(p);
        poll_backlog.push_back(rand_poll(1'b0));
        // five repeats reach the limit, the sixth stays stuck
        repeat (6) poll_backlog.push_back(p);
        poll_backlog.push_back(rand_poll(1'b1));
        wait_drained();

        // extreme offsets, zero divider and zero limit: every good read is stuck
        write_reg(CFG_GYRO_OFS_X, 16'h7FFF);
        write_reg(CFG_GYRO_OFS_Y, 16'h8000);
        write_reg(CFG_GYRO_OFS_Z, 16'hFFFF);
        write_reg(CFG_MAG_DIVIDER, 16'd0);
        write_reg(CFG_REPEAT_LIM, 16'd0);
        @(negedge i_clk);
        poll_backlog.push_back(rand_poll(1'b1));
        poll_backlog.push_back(rand_poll(1'b0));
        wait_drained();

        // limit 1, mag due on every accepted poll; good and bad mag reads
        write_reg(CFG_REPEAT_LIM, 16'd1);
        @(negedge i_clk);
        p = rand_poll(1'b1);
        p.mag_ok = 1'b1;
        poll_backlog.push_back(p);
        q = rand_poll(1'b1);
        q.mag_ok = 1'b0;
        poll_backlog.push_back(q);
        poll_backlog.push_back(q);
        wait_drained();

        // divider lowered below the running phase
        write_reg(CFG_MAG_DIVIDER, 16'd255);
        write_reg(CFG_REPEAT_LIM, 16'd255);
        @(negedge i_clk);
        repeat (3) poll_backlog.push_back(rand_poll(1'b1));
        wait_drained();
        write_reg(CFG_MAG_DIVIDER, 16'd2);
        @(negedge i_clk);
        poll_backlog.push_back(rand_poll(1'b1));
        wait_drained();

        // ---- random phases, new settings each time
        for (k = 0; k < 10; k++) begin
            choose_settings();
            @(negedge i_clk);
            // first phase fully throttled, second at full rate, rest mixed
            idle_tx = (k == 0) ? 1'b1 : (k == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            idle_rx = (k == 0) ? 1'b1 : (k == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            queue_traffic(60);
            wait_drained();
        end

        // ---- repeat count saturation: 300 identical polls at limit 255;
        // a wrapping count would let poll 257 through
        write_reg(CFG_REPEAT_LIM, 16'd255);
        @(negedge i_clk);
        p = rand_poll(1'b1);
        repeat (300) poll_backlog.push_back(p);
        poll_backlog.push_back(rand_poll(1'b1));
        wait_drained();

        // ---- a last mixed phase with stalls on both sides
        choose_settings();
        @(negedge i_clk);
        idle_tx = 1'b1;
        idle_rx = 1'b1;
        queue_traffic(60);
        wait_drained();

        repeat (4) @(negedge i_clk);
        if (bad_count == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[imu_sample_stuck_check.f]
sv/isc_pkg.sv
sv/isc_lane.sv
sv/isc_merge.sv
sv/imu_sample_stuck_check.sv
sv/isc_checker.sv
tb/tb_imu_sample_stuck_check.sv
